/* hw/rtl/fuvt_pkg.sv */
// Shared types and constants of the first unique value tracker.
// Holds the value width, the status codes, the cell entry and the cell control types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fuvt_pkg;

  localparam int VALUE_BITS = 8;
  localparam int DEPTH      = 1 << VALUE_BITS;
  localparam int COUNT_BITS = VALUE_BITS + 1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Per-value status as kept in the status memory.
  typedef enum logic [1:0] {
    ST_UNSEEN = 2'd0,
    ST_ONCE   = 2'd1,
    ST_DUP    = 2'd2
  } status_t;

  // One queued candidate: its value and whether it has since been seen again.
  typedef struct packed {
    logic   dup;
    value_t value;
  } entry_t;

  // Broadcast control from the sequencer to every cell of the queue.
  typedef struct packed {
    logic   shift;
    logic   append;
    logic   mark;
    value_t value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_PRUNE,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/fuvt_status_mem.sv */
// Status memory of the tracker: one status code per possible value.
// Registered read, one write port, per-entry valid bits cleared at reset.
// Depends on fuvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fuvt_status_mem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire fuvt_pkg::value_t  rd_addr,
  output fuvt_pkg::status_t      rd_status,
  input  wire logic              wr_en,
  input  wire fuvt_pkg::value_t  wr_addr,
  input  wire fuvt_pkg::status_t wr_status
);

  fuvt_pkg::status_t             mem [fuvt_pkg::DEPTH];
  logic [fuvt_pkg::DEPTH-1:0]    vld_r;
  fuvt_pkg::status_t             rd_data_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_status;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // An entry never written reads as unseen.
  assign rd_status = rd_vld_r ? rd_data_r : fuvt_pkg::ST_UNSEEN;

endmodule

`default_nettype wire

/* hw/rtl/fuvt_cell.sv */
// One cell of the candidate queue chain.
// Shifts towards the head, takes an appended value, or marks itself duplicated.
// Depends on fuvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fuvt_cell (
  input  wire logic                clk,
  input  wire fuvt_pkg::cell_ctrl_t ctrl,
  input  wire logic                sel,
  input  wire fuvt_pkg::entry_t    from_next,
  output fuvt_pkg::entry_t         entry
);

  fuvt_pkg::entry_t entry_r;
  fuvt_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.shift) begin
      entry_nxt = from_next;
    end else if (ctrl.append && sel) begin
      entry_nxt.value = ctrl.value;
      entry_nxt.dup   = 1'b0;
    end else if (ctrl.mark && (entry_r.value == ctrl.value)) begin
      entry_nxt.dup = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

/* hw/rtl/first_unique_value_tracker_core.sv */
// Top level of the first unique value tracker.
// Instantiates fuvt_status_mem and a chain of fuvt_cell; uses fuvt_pkg.
//
// Usage. Values arrive on the in_ channel (in_valid, in_value, in_stall) one beat
// at a time. Every accepted beat yields exactly one result beat on the out_
// channel: out_first_unique is the oldest value seen exactly once so far and
// out_found says whether such a value exists (out_first_unique is zero if not).
// Timing. After a beat is accepted its status is read from the status memory and
// the queue of cells is updated. A first sighting or a later repeat is settled in
// the evaluate state. A second sighting first marks the cells, then retires
// duplicated cells from the head one per cycle, and its result is loaded once
// the head is no longer duplicated.
// The result sits in an output register, so the next input beat is accepted
// while a result still waits. If the receiver stalls for long, the sequencer
// holds the finished result internally and in_stall stays high until the output
// register has been emptied.
// Reset. rst_n is synchronous and active low; it clears every status valid bit
// (all values unseen), empties the queue and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none

module first_unique_value_tracker_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire fuvt_pkg::value_t in_value,
  output logic                  in_stall,
  output logic                  out_valid,
  output fuvt_pkg::value_t      out_first_unique,
  output logic                  out_found,
  input  wire logic             out_stall
);

  fuvt_pkg::state_t     state_r;
  fuvt_pkg::state_t     state_nxt;
  fuvt_pkg::value_t     val_r;
  fuvt_pkg::count_t     count_r;
  fuvt_pkg::count_t     count_nxt;
  logic                 out_valid_r;
  fuvt_pkg::value_t     out_first_r;
  logic                 out_found_r;

  fuvt_pkg::status_t    st;
  logic                 rd_en;
  logic                 wr_en;
  fuvt_pkg::status_t    wr_status;
  fuvt_pkg::cell_ctrl_t ctrl;
  logic                 load_out;
  fuvt_pkg::value_t     res_value;
  logic                 res_found;
  logic                 out_free;
  logic                 prune_go;

  fuvt_pkg::entry_t     entries [fuvt_pkg::DEPTH];
  fuvt_pkg::entry_t     head;

  assign out_free = !out_valid_r || !out_stall;
  assign head     = entries[0];
  // The head must go when it has been seen a second time.
  assign prune_go = (count_r != '0) && head.dup;

  fuvt_status_mem u_status (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_addr   (in_value),
    .rd_status (st),
    .wr_en     (wr_en),
    .wr_addr   (val_r),
    .wr_status (wr_status)
  );

  // The queue: cell 0 is the head and each cell takes its right neighbour on a
  // shift. The cell whose index equals the count takes an appended value.
  for (genvar i = 0; i < fuvt_pkg::DEPTH; i++) begin : g_cell
    fuvt_pkg::entry_t nb;
    if (i == fuvt_pkg::DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = entries[i+1];
    end
    fuvt_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .sel       (count_r == fuvt_pkg::count_t'(i)),
      .from_next (nb),
      .entry     (entries[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fuvt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = fuvt_pkg::S_EVAL;
        end
      end
      fuvt_pkg::S_EVAL: begin
        if (st == fuvt_pkg::ST_ONCE) begin
          state_nxt = fuvt_pkg::S_PRUNE;
        end else if (out_free) begin
          state_nxt = fuvt_pkg::S_IDLE;
        end else begin
          state_nxt = fuvt_pkg::S_EMIT;
        end
      end
      fuvt_pkg::S_PRUNE: begin
        if (!prune_go) begin
          state_nxt = out_free ? fuvt_pkg::S_IDLE : fuvt_pkg::S_EMIT;
        end
      end
      fuvt_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = fuvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fuvt_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: memory access, cell control and result load.
  always_comb begin
    in_stall    = 1'b1;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_status   = fuvt_pkg::ST_ONCE;
    ctrl.shift  = 1'b0;
    ctrl.append = 1'b0;
    ctrl.mark   = 1'b0;
    ctrl.value  = val_r;
    load_out    = 1'b0;
    res_found   = (count_r != '0);
    res_value   = res_found ? head.value : '0;
    case (state_r)
      fuvt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
      end
      fuvt_pkg::S_EVAL: begin
        case (st)
          fuvt_pkg::ST_UNSEEN: begin
            wr_en       = 1'b1;
            wr_status   = fuvt_pkg::ST_ONCE;
            ctrl.append = 1'b1;
            load_out    = out_free;
            // An empty queue gets this value as its new head.
            if (count_r == '0) begin
              res_value = val_r;
              res_found = 1'b1;
            end
          end
          fuvt_pkg::ST_ONCE: begin
            wr_en     = 1'b1;
            wr_status = fuvt_pkg::ST_DUP;
            ctrl.mark = 1'b1;
          end
          default: begin
            load_out = out_free;
          end
        endcase
      end
      fuvt_pkg::S_PRUNE: begin
        if (prune_go) begin
          ctrl.shift = 1'b1;
        end else begin
          load_out = out_free;
        end
      end
      fuvt_pkg::S_EMIT: begin
        load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.append) begin
      count_nxt = count_r + fuvt_pkg::count_t'(1);
    end else if (ctrl.shift) begin
      count_nxt = count_r - fuvt_pkg::count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fuvt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      val_r <= in_value;
    end
    if (load_out) begin
      out_first_r <= res_value;
      out_found_r <= res_found;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_unique = out_first_r;
  assign out_found        = out_found_r;

  // The queue never holds more entries than there are values.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fuvt_pkg::count_t'(fuvt_pkg::DEPTH))
    else $error("queue count above capacity");

  // An append never lands on a full queue.
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.append |-> (count_r < fuvt_pkg::count_t'(fuvt_pkg::DEPTH)))
    else $error("append into a full queue");

  // The head is retired only from a non-empty queue.
  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift |-> (count_r != '0))
    else $error("shift of an empty queue");

  // An accepted beat is evaluated in the following cycle.
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == fuvt_pkg::S_EVAL))
    else $error("accepted beat not evaluated");

  // A result without a unique value carries zero.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_first_r == '0))
    else $error("non-zero value with found low");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for first_unique_value_tracker_core.
// Depends on fuvt_pkg and the core. Sends value beats from a directed table, then
// a random stream, and checks every result against a typed row or a bench tracker.
`timescale 1ns / 1ps

module tb;
  import fuvt_pkg::*;

  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM   = 1000;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_REPORTS  = 10;

  // One result beat: the oldest value seen exactly once, and whether there is one.
  typedef struct packed {
    value_t first_unique;
    logic   found;
  } unique_res_t;

  // One row of the directed table. Where typed is set, the row carries its own
  // expected result; otherwise the tracker below supplies it.
  typedef struct packed {
    value_t value;
    logic   typed;
    value_t first_unique;
    logic   found;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIRECTED] = '{
    '{8'd0,   1'b1, 8'd0,   1'b1},  // very first value after reset
    '{8'd255, 1'b1, 8'd0,   1'b1},  // largest value; the oldest is still zero
    '{8'd0,   1'b1, 8'd255, 1'b1},  // second sighting retires the head
    '{8'd255, 1'b1, 8'd0,   1'b0},  // nothing seen exactly once is left
    '{8'd255, 1'b1, 8'd0,   1'b0},  // a third sighting changes nothing
    '{8'd0,   1'b1, 8'd0,   1'b0},
    '{8'd1,   1'b1, 8'd1,   1'b1},  // a fresh value after an empty queue
    '{8'd2,   1'b0, 8'd0,   1'b0},  // walking one across every input bit
    '{8'd4,   1'b0, 8'd0,   1'b0},
    '{8'd8,   1'b0, 8'd0,   1'b0},
    '{8'd16,  1'b0, 8'd0,   1'b0},
    '{8'd32,  1'b0, 8'd0,   1'b0},
    '{8'd64,  1'b0, 8'd0,   1'b0},
    '{8'd128, 1'b0, 8'd0,   1'b0},
    '{8'd2,   1'b0, 8'd0,   1'b0},  // duplicates behind the head: no retirement yet
    '{8'd4,   1'b0, 8'd0,   1'b0},
    '{8'd8,   1'b0, 8'd0,   1'b0},
    '{8'd1,   1'b0, 8'd0,   1'b0},  // head duplicated: four cells retire in a row
    '{8'd170, 1'b0, 8'd0,   1'b0},  // alternating bit patterns
    '{8'd85,  1'b0, 8'd0,   1'b0},
    '{8'd16,  1'b0, 8'd0,   1'b0},
    '{8'd32,  1'b0, 8'd0,   1'b0}
  };

  logic   clk              = 1'b0;
  logic   rst_n            = 1'b0;
  logic   in_valid         = 1'b0;
  value_t in_value         = '0;
  logic   in_stall;
  logic   out_valid;
  value_t out_first_unique;
  logic   out_found;
  logic   out_stall        = 1'b0;

  // Idle rates in per cent for the sending and the receiving side, and the
  // request for one long hold-off on the receiving side.
  int send_idle_pct = 37;
  int recv_idle_pct = 62;
  bit hold_req      = 1'b0;

  int error_count = 0;
  int cycle_count = 0;

  // The tracker's own copy of the block state: one status per value and the
  // candidate queue in order of first sighting.
  status_t     value_state [DEPTH];
  value_t      cand_q [$];
  // Results owed by the block, oldest first.
  unique_res_t pending_uniques [$];

  first_unique_value_tracker_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_value         (in_value),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_first_unique (out_first_unique),
    .out_found        (out_found),
    .out_stall        (out_stall)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Runaway guard: the slowest legal run is far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Advances the tracker by one value and returns the result the block owes.
  // A first sighting queues the value; a second marks it duplicated and then
  // retires the run of duplicated entries at the head. Later repeats are ignored.
  task automatic track_value(input value_t v, output unique_res_t res);
    case (value_state[v])
      ST_UNSEEN: begin
        value_state[v] = ST_ONCE;
        cand_q.push_back(v);
      end
      ST_ONCE: begin
        value_state[v] = ST_DUP;
        while (cand_q.size() != 0 && value_state[cand_q[0]] != ST_ONCE) begin
          void'(cand_q.pop_front());
        end
      end
      default: ;
    endcase
    if (cand_q.size() != 0) begin
      res.first_unique = cand_q[0];
      res.found        = 1'b1;
    end else begin
      res = '0;
    end
  endtask

  // Offers one value beat, with random idle cycles in front of it, and waits
  // until the block takes it. The expected result is recorded at acceptance.
  // in_valid stays high from one beat to the next when no idle cycle falls
  // between them, so it is never lowered and raised in the same time step.
  task automatic send_value(input value_t v, input logic typed, input unique_res_t typed_res);
    unique_res_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_value(v, res);
    pending_uniques.push_back(typed ? typed_res : res);
  endtask

  // Receiving side. Every cycle it decides afresh whether to stall, except
  // during the one long hold-off, which it counts out itself while the sender
  // keeps offering beats, so that the output register and the held result fill
  // and the block has to stall its input.
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Result checker. Both sides are sampled at the rising edge, before any
  // update of that edge takes effect, so a beat counts exactly when the block
  // sees it leave.
  always @(posedge clk) begin
    unique_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_uniques.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected result beat: first_unique=%0d found=%0b",
                   out_first_unique, out_found);
        end
      end else begin
        want = pending_uniques.pop_front();
        if (out_first_unique !== want.first_unique || out_found !== want.found) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("result mismatch: first_unique exp %0d got %0d, found exp %0b got %0b",
                     want.first_unique, out_first_unique, want.found, out_found);
          end
        end
      end
    end
  end

  // Main flow: reset, the directed table, then the random stream in three
  // idling phases, with one drain pause and one long receiver hold-off.
  initial begin
    unique_res_t typed_res;
    value_t      fresh_vals [$];
    value_t      seen_vals [$];
    value_t      v;
    value_t      swap_val;
    int          r;
    int          n;
    int          j;
    int          roll;
    int          fresh_pct;

    foreach (value_state[i]) value_state[i] = ST_UNSEEN;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_DIRECTED; r++) begin
      typed_res.first_unique = DIR_ROWS[r].first_unique;
      typed_res.found        = DIR_ROWS[r].found;
      send_value(DIR_ROWS[r].value, DIR_ROWS[r].typed, typed_res);
    end

    // Values still unseen are introduced in a shuffled order, so that first
    // sightings are spread over the whole run rather than used up at once.
    for (r = 0; r < DEPTH; r++) begin
      if (value_state[r] == ST_UNSEEN) fresh_vals.push_back(value_t'(r));
      else seen_vals.push_back(value_t'(r));
    end
    for (r = fresh_vals.size() - 1; r > 0; r--) begin
      j = $urandom_range(0, r);
      swap_val      = fresh_vals[r];
      fresh_vals[r] = fresh_vals[j];
      fresh_vals[j] = swap_val;
    end

    for (n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 37;
      end
      if (n == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Let the block run completely dry once before carrying on.
      if (n == NUM_RANDOM / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_uniques.size() != 0) @(posedge clk);
      end
      // The long hold-off falls where the sender no longer idles.
      if (n == 5 * NUM_RANDOM / 6) hold_req = 1'b1;

      // Mostly first and second sightings of live candidates, which is what
      // moves the queue; a burst of first sightings builds a long queue; the
      // rest are repeats of old values and plain noise.
      fresh_pct = (n >= 400 && n < 470) ? 90 : 18;
      roll      = $urandom_range(0, 99);
      if (roll < fresh_pct && fresh_vals.size() != 0) begin
        v = fresh_vals.pop_front();
        seen_vals.push_back(v);
      end else if (roll >= 95 || seen_vals.size() == 0) begin
        v = value_t'($urandom_range(0, DEPTH - 1));
      end else if (roll < 65 && cand_q.size() != 0) begin
        v = cand_q[$urandom_range(0, cand_q.size() - 1)];
      end else begin
        v = seen_vals[$urandom_range(0, seen_vals.size() - 1)];
      end
      send_value(v, 1'b0, '0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_uniques.size() != 0) @(posedge clk);
    // A few more cycles to catch any stray beat after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
